// ===== rtl/nst_pkg.sv =====
// shared types, codes and the name canonicalizing function of the name set table
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

    localparam int MAX_NAMES_DEF = 16;
    localparam int FUNC_W        = 2;
    localparam int HEAD_W        = 64;
    localparam int TAIL_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 5;

    typedef enum logic [FUNC_W-1:0] {
        F_CREATE = 2'd0,
        F_DELETE = 2'd1,
        F_SEARCH = 2'd2,
        F_LIST   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
    } t_entry;

    // clear every byte after the first zero byte of the name
    function automatic t_entry canon(logic [HEAD_W-1:0] head, logic [TAIL_W-1:0] tail);
        t_entry e;
        logic   ended;
        ended  = 1'b0;
        e.head = '0;
        for (int b = 0; b < HEAD_W / 8; b++) begin
            if (head[8*b +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                e.head[8*b +: 8] = head[8*b +: 8];
            end
        end
        e.tail = ended ? '0 : tail;
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nst_if.sv =====
// request and response channel interfaces of the name set table
`timescale 1ns / 1ps
`default_nettype none

interface nst_req_if;
    logic                       valid;
    logic                       ready;
    logic [nst_pkg::FUNC_W-1:0] func;
    logic [nst_pkg::HEAD_W-1:0] name_head;
    logic [nst_pkg::TAIL_W-1:0] name_tail;

    modport source (output valid, output func, output name_head, output name_tail,
                    input ready);
    modport sink   (input valid, input func, input name_head, input name_tail,
                    output ready);
endinterface

interface nst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [nst_pkg::STATUS_W-1:0] status;
    logic [nst_pkg::HEAD_W-1:0]   entry_head;
    logic [nst_pkg::TAIL_W-1:0]   entry_tail;
    logic [nst_pkg::COUNT_W-1:0]  entry_count;
    logic                         last;

    modport source (output valid, output status, output entry_head, output entry_tail,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input entry_head, input entry_tail,
                    input entry_count, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/name_set_table_core.sv =====
// name set table: a ring of name cells with a scan sequencer and a response register
//
// Requests arrive on i_req (func, name_head, name_tail) and responses leave on
// o_rsp (status, entry_head, entry_tail, entry_count, last), both valid/ready.
// Names are held in a ring of MAX_NAMES cells that rotates one position per
// cycle during a scan (a list scan can be held, see below); cell 0 is
// compared with the request name (or listed) as entries pass. Every request
// except a list of an empty table rotates the ring once round, so the ring is
// back in storage order afterwards. Create and delete then update a cell in
// S_DONE, where create, delete and search load the response. A list of an
// empty table goes straight to S_DONE. A list gives one item per stored name,
// lowest slot first, last set on the final one.
// One request is in flight at a time: i_req.ready is high only when idle.
// The response register lets the next request be accepted while a response
// still waits. When the receiver stalls, a list scan holds the ring until the
// pending item is taken; other requests hold in their final cycle.
// Reset empties the table (count to zero) and drops any pending response;
// the cell contents are not cleared and are never read above the count.
`timescale 1ns / 1ps
`default_nettype none

module name_set_table_core #(
    parameter int MAX_NAMES = nst_pkg::MAX_NAMES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nst_req_if.sink    i_req,
    nst_rsp_if.source  o_rsp
);

    localparam int IW = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
    localparam int CW = $clog2(MAX_NAMES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    nst_pkg::t_func                r_func, n_func;
    nst_pkg::t_entry               r_key, n_key;
    logic [IW-1:0]                 r_step, n_step;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_found, n_found;
    logic [IW-1:0]                 r_pos, n_pos;
    nst_pkg::t_entry               r_tail_e, n_tail_e;
    logic                          r_ovalid, n_ovalid;
    nst_pkg::t_status              r_status, n_status;
    logic [nst_pkg::HEAD_W-1:0]    r_ehead, n_ehead;
    logic [nst_pkg::TAIL_W-1:0]    r_etail, n_etail;
    logic [nst_pkg::COUNT_W-1:0]   r_ecount, n_ecount;
    logic                          r_olast, n_olast;

    nst_pkg::t_entry               w_cell [MAX_NAMES];
    logic [MAX_NAMES-1:0]          w_load;
    nst_pkg::t_entry               w_load_data;
    logic                          w_shift;
    logic                          w_free;
    logic                          w_in_use;
    logic [CW-1:0]                 w_kx;
    logic                          w_emit;
    nst_pkg::t_status              w_st;
    nst_pkg::t_entry               w_oentry;
    logic                          w_olast;
    logic                          w_ld_cr;
    logic                          w_ld_del;
    logic [CW+nst_pkg::COUNT_W-1:0] w_cnt_wide;

    // the ring: each cell takes its upper neighbor, the top wraps to cell 0's value
    for (genvar g = 0; g < MAX_NAMES; g++) begin : g_cell
        nst_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_load      (w_load[g]),
            .i_next      (w_cell[(g + 1) % MAX_NAMES]),
            .i_load_data (w_load_data),
            .o_entry     (w_cell[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_key    = r_key;
        n_step   = r_step;
        n_count  = r_count;
        n_found  = r_found;
        n_pos    = r_pos;
        n_tail_e = r_tail_e;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_ehead  = r_ehead;
        n_etail  = r_etail;
        n_ecount = r_ecount;
        n_olast  = r_olast;
        w_shift  = 1'b0;
        w_emit   = 1'b0;
        w_st     = nst_pkg::ST_OK;
        w_oentry = '0;
        w_olast  = 1'b1;
        w_ld_cr  = 1'b0;
        w_ld_del = 1'b0;
        w_free   = !r_ovalid || o_rsp.ready;
        w_in_use = CW'(r_step) < r_count;
        w_kx     = CW'(r_step) + CW'(1);

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = nst_pkg::t_func'(i_req.func);
                    n_key   = nst_pkg::canon(i_req.name_head, i_req.name_tail);
                    n_step  = '0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    if (i_req.func == nst_pkg::F_LIST && r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // a list scan only moves when the response register can take an item
                if (r_func != nst_pkg::F_LIST || w_free) begin
                    w_shift = 1'b1;
                    n_step  = r_step + 1'b1;
                    if (w_in_use && w_cell[0] == r_key && !r_found) begin
                        n_found = 1'b1;
                        n_pos   = r_step;
                    end
                    if (w_kx == r_count) begin
                        n_tail_e = w_cell[0];
                    end
                    if (r_func == nst_pkg::F_LIST && w_in_use) begin
                        w_emit   = 1'b1;
                        w_st     = nst_pkg::ST_ENTRY;
                        w_oentry = w_cell[0];
                        w_olast  = (w_kx == r_count);
                    end
                    if (r_step == IW'(MAX_NAMES - 1)) begin
                        n_state = (r_func == nst_pkg::F_LIST) ? S_IDLE : S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_free) begin
                    n_state = S_IDLE;
                    w_emit  = 1'b1;
                    case (r_func)
                        nst_pkg::F_CREATE: begin
                            if (r_found) begin
                                w_st = nst_pkg::ST_EXISTS;
                            end else if (r_count == CW'(MAX_NAMES)) begin
                                w_st = nst_pkg::ST_FULL;
                            end else begin
                                w_ld_cr = 1'b1;
                                n_count = r_count + 1'b1;
                                w_st    = nst_pkg::ST_OK;
                            end
                        end
                        nst_pkg::F_DELETE: begin
                            if (!r_found) begin
                                w_st = nst_pkg::ST_NOT_FOUND;
                            end else begin
                                // the last entry fills the hole
                                w_ld_del = 1'b1;
                                n_count  = r_count - 1'b1;
                                w_st     = nst_pkg::ST_OK;
                            end
                        end
                        nst_pkg::F_SEARCH: begin
                            w_st = r_found ? nst_pkg::ST_OK : nst_pkg::ST_NOT_FOUND;
                        end
                        default: begin
                            w_st = nst_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        for (int i = 0; i < MAX_NAMES; i++) begin
            w_load[i] = (w_ld_cr && r_count == CW'(i)) || (w_ld_del && r_pos == IW'(i));
        end
        w_load_data = w_ld_del ? r_tail_e : r_key;

        // count goes out modulo the port width
        w_cnt_wide = {{nst_pkg::COUNT_W{1'b0}}, n_count};
        if (w_emit) begin
            n_ovalid = 1'b1;
            n_status = w_st;
            n_ehead  = w_oentry.head;
            n_etail  = w_oentry.tail;
            n_ecount = w_cnt_wide[nst_pkg::COUNT_W-1:0];
            n_olast  = w_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_step   <= n_step;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_tail_e <= n_tail_e;
        r_status <= n_status;
        r_ehead  <= n_ehead;
        r_etail  <= n_etail;
        r_ecount <= n_ecount;
        r_olast  <= n_olast;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_head  = r_ehead;
    assign o_rsp.entry_tail  = r_etail;
    assign o_rsp.entry_count = r_ecount;
    assign o_rsp.last        = r_olast;

endmodule

`default_nettype wire

// ===== rtl/nst_cell.sv =====
// one storage cell of the rotating name ring
`timescale 1ns / 1ps
`default_nettype none

module nst_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire logic            i_load,
    input  wire nst_pkg::t_entry i_next,
    input  wire nst_pkg::t_entry i_load_data,
    output nst_pkg::t_entry      o_entry
);

    nst_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== rtl/nst_checker.sv =====
// port-level checks of the name set table and their bind
`timescale 1ns / 1ps
`default_nettype none

module nst_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [nst_pkg::STATUS_W-1:0] i_status,
    input wire logic [nst_pkg::HEAD_W-1:0]   i_head,
    input wire logic [nst_pkg::TAIL_W-1:0]   i_tail,
    input wire logic [nst_pkg::COUNT_W-1:0]  i_count,
    input wire logic                         i_last
);

    // a stalled response holds its status, name and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_head) && $stable(i_tail) && $stable(i_last))
        else $error("response changed while stalled");

    // one request in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    // only list entries carry a name
    a_name_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != nst_pkg::ST_ENTRY |-> i_head == '0 && i_tail == '0)
        else $error("name on a non-list response");

    // empty list is a single final item with a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == nst_pkg::ST_EMPTY |-> i_last && i_count == '0)
        else $error("bad empty list response");

endmodule

bind name_set_table_core nst_checker u_nst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_head      (o_rsp.entry_head),
    .i_tail      (o_rsp.entry_tail),
    .i_count     (o_rsp.entry_count),
    .i_last      (o_rsp.last)
);

`default_nettype wire

// ===== sim/tb_name_set_table_core.sv =====
// self-checking testbench of the name set table core with its own table model and result queue
`timescale 1ns / 1ps

module tb_name_set_table_core;

    localparam int TBL_DEPTH = nst_pkg::MAX_NAMES_DEF;
    localparam int POOL_SIZE = 20;
    localparam int NUM_RANDOM = 320;

    typedef struct packed {
        nst_pkg::t_status                    status;
        logic [nst_pkg::HEAD_W-1:0]          head;
        logic [nst_pkg::TAIL_W-1:0]          tail;
        logic [nst_pkg::COUNT_W-1:0]         count;
        logic                                last;
    } t_table_reply;

    class name_table_scoreboard;
        logic [nst_pkg::HEAD_W-1:0] heads [TBL_DEPTH];
        logic [nst_pkg::TAIL_W-1:0] tails [TBL_DEPTH];
        int unsigned                count;
        t_table_reply               replies_due [$];
        int                         errors;
        int                         requests [4];
        int                         replies_seen;
        int                         full_hits;

        function new();
            count        = 0;
            errors       = 0;
            replies_seen = 0;
            full_hits    = 0;
            foreach (requests[i]) requests[i] = 0;
        endfunction

        // drop every byte after the first zero of the name
        function nst_pkg::t_entry trim_name(logic [nst_pkg::HEAD_W-1:0] head,
                                            logic [nst_pkg::TAIL_W-1:0] tail);
            nst_pkg::t_entry e;
            bit              done;
            done   = 1'b0;
            e.head = '0;
            for (int b = 0; b < 8; b++) begin
                if (head[8*b +: 8] == 8'h00) begin
                    done = 1'b1;
                end
                if (!done) begin
                    e.head[8*b +: 8] = head[8*b +: 8];
                end
            end
            e.tail = done ? 8'h00 : tail;
            return e;
        endfunction

        function int locate(nst_pkg::t_entry e);
            for (int i = 0; i < int'(count); i++) begin
                if (heads[i] == e.head && tails[i] == e.tail) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void push_reply(nst_pkg::t_status st, logic [nst_pkg::HEAD_W-1:0] head,
                                 logic [nst_pkg::TAIL_W-1:0] tail, logic last);
            t_table_reply r;
            r.status = st;
            r.head   = head;
            r.tail   = tail;
            r.count  = nst_pkg::COUNT_W'(count);
            r.last   = last;
            replies_due.push_back(r);
        endfunction

        function void note_request(nst_pkg::t_func op, logic [nst_pkg::HEAD_W-1:0] head,
                                   logic [nst_pkg::TAIL_W-1:0] tail);
            nst_pkg::t_entry e;
            int              pos;
            e   = trim_name(head, tail);
            pos = locate(e);
            requests[int'(op)]++;
            case (op)
                nst_pkg::F_CREATE: begin
                    if (pos >= 0) begin
                        push_reply(nst_pkg::ST_EXISTS, '0, '0, 1'b1);
                    end else if (count >= TBL_DEPTH) begin
                        full_hits++;
                        push_reply(nst_pkg::ST_FULL, '0, '0, 1'b1);
                    end else begin
                        heads[count] = e.head;
                        tails[count] = e.tail;
                        count++;
                        push_reply(nst_pkg::ST_OK, '0, '0, 1'b1);
                    end
                end
                nst_pkg::F_DELETE: begin
                    if (pos < 0) begin
                        push_reply(nst_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                    end else begin
                        // last entry fills the hole
                        heads[pos] = heads[count-1];
                        tails[pos] = tails[count-1];
                        count--;
                        push_reply(nst_pkg::ST_OK, '0, '0, 1'b1);
                    end
                end
                nst_pkg::F_SEARCH: begin
                    push_reply((pos >= 0) ? nst_pkg::ST_OK : nst_pkg::ST_NOT_FOUND,
                               '0, '0, 1'b1);
                end
                default: begin
                    if (count == 0) begin
                        push_reply(nst_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(count); i++) begin
                            push_reply(nst_pkg::ST_ENTRY, heads[i], tails[i],
                                       (i == int'(count) - 1));
                        end
                    end
                end
            endcase
        endfunction

        function void check_response(logic [nst_pkg::STATUS_W-1:0] status,
                                     logic [nst_pkg::HEAD_W-1:0] head,
                                     logic [nst_pkg::TAIL_W-1:0] tail,
                                     logic [nst_pkg::COUNT_W-1:0] cnt,
                                     logic last);
            t_table_reply want;
            replies_seen++;
            if (replies_due.size() == 0) begin
                $error("result with none expected: status %0d head %h count %0d",
                       status, head, cnt);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (head !== want.head) begin
                $error("entry_head: expected %h, got %h", want.head, head);
                errors++;
            end
            if (tail !== want.tail) begin
                $error("entry_tail: expected %h, got %h", want.tail, tail);
                errors++;
            end
            if (cnt !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, cnt);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nst_req_if req_if ();
    nst_rsp_if rsp_if ();

    name_set_table_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    name_table_scoreboard sb;

    int         pool_len [POOL_SIZE];
    logic [7:0] pool_chars [POOL_SIZE][9];

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(15_000_000);
        $error("timeout with %0d results still expected", sb.replies_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // pool name with random junk after its terminator, if it has one
    function automatic void pool_name(input int idx, output logic [nst_pkg::HEAD_W-1:0] head,
                                      output logic [nst_pkg::TAIL_W-1:0] tail);
        logic [7:0] bytes [9];
        for (int b = 0; b < 9; b++) begin
            if (b < pool_len[idx]) begin
                bytes[b] = pool_chars[idx][b];
            end else if (b == pool_len[idx]) begin
                bytes[b] = 8'h00;
            end else begin
                bytes[b] = 8'($urandom_range(0, 255));
            end
        end
        for (int b = 0; b < 8; b++) begin
            head[8*b +: 8] = bytes[b];
        end
        tail = bytes[8];
    endfunction

    task automatic send_request(input nst_pkg::t_func op,
                                input logic [nst_pkg::HEAD_W-1:0] head,
                                input logic [nst_pkg::TAIL_W-1:0] tail);
        req_if.valid     <= 1'b1;
        req_if.func      <= op;
        req_if.name_head <= head;
        req_if.name_tail <= tail;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_request(op, head, tail);
    endtask

    task automatic idle_sender(input int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.replies_due.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.status, rsp_if.entry_head, rsp_if.entry_tail,
                              rsp_if.entry_count, rsp_if.last);
        end
    end

    // receiver stalls: runs of always ready, random, mostly ready and long stalls
    initial begin
        int mode;
        int span;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                    default: rsp_if.ready <= ((k % 14) >= 12);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin
        logic [nst_pkg::HEAD_W-1:0] head;
        logic [nst_pkg::TAIL_W-1:0] tail;
        nst_pkg::t_func             op;
        int                         burst_left;
        int                         roll;
        bit                         grow;

        sb = new();
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.func      <= nst_pkg::F_CREATE;
        req_if.name_head <= '0;
        req_if.name_tail <= '0;

        // distinct first characters keep the pool names unique
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = $urandom_range(1, 9);
            pool_chars[i][0] = 8'(1 + i * 10 + $urandom_range(0, 9));
            for (int b = 1; b < 9; b++) begin
                pool_chars[i][b] = 8'($urandom_range(1, 255));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_request(nst_pkg::F_LIST, '0, '0);
        send_request(nst_pkg::F_SEARCH, 64'h0000_0000_0042_4241, 8'h00);
        send_request(nst_pkg::F_DELETE, 64'h0000_0000_0042_4241, 8'h00);
        send_request(nst_pkg::F_CREATE, 64'h0, 8'h5A);
        send_request(nst_pkg::F_CREATE, '1, 8'hFF);
        send_request(nst_pkg::F_CREATE, 64'hDEAD_BEEF_1234_00F5, 8'h77);
        send_request(nst_pkg::F_CREATE, 64'h0102_0304_0506_00F5, 8'hFF);
        send_request(nst_pkg::F_SEARCH, 64'h0000_0000_0000_00F5, 8'h00);
        send_request(nst_pkg::F_DELETE, 64'h8000_0000_0000_0000, 8'h01);
        send_request(nst_pkg::F_LIST, '0, '0);
        for (int i = 0; i < 14; i++) begin
            pool_name(i, head, tail);
            send_request(nst_pkg::F_CREATE, head, tail);
        end
        pool_name(14, head, tail);
        send_request(nst_pkg::F_CREATE, head, tail);
        send_request(nst_pkg::F_CREATE, '1, 8'hFF);
        send_request(nst_pkg::F_LIST, '0, '0);
        wait_drained();

        // random part: alternating growing and shrinking phases over a small name pool
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            grow = ((n / 40) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (grow) begin
                op = (roll < 55) ? nst_pkg::F_CREATE : (roll < 70) ? nst_pkg::F_DELETE :
                     (roll < 85) ? nst_pkg::F_SEARCH : nst_pkg::F_LIST;
            end else begin
                op = (roll < 15) ? nst_pkg::F_CREATE : (roll < 60) ? nst_pkg::F_DELETE :
                     (roll < 80) ? nst_pkg::F_SEARCH : nst_pkg::F_LIST;
            end
            if ($urandom_range(0, 9) == 0) begin
                head = {$urandom, $urandom};
                tail = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) begin
                    head[7:0] = 8'h00;
                end
            end else begin
                pool_name($urandom_range(0, POOL_SIZE - 1), head, tail);
            end
            send_request(op, head, tail);

            if (n % 80 == 79) begin
                wait_drained();
            end
            burst_left--;
            if (burst_left == 0) begin
                idle_sender($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.replies_due.size() != 0) begin
            $error("%0d expected results never arrived", sb.replies_due.size());
            sb.errors++;
        end

        $display("covered %0d requests: %0d create, %0d delete, %0d search, %0d list",
                 sb.requests[0] + sb.requests[1] + sb.requests[2] + sb.requests[3],
                 sb.requests[0], sb.requests[1], sb.requests[2], sb.requests[3]);
        $display("%0d results checked, create refused on a full table %0d times",
                 sb.replies_seen, sb.full_hits);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nst_pkg.sv
rtl/nst_if.sv
rtl/nst_cell.sv
rtl/name_set_table_core.sv
rtl/nst_checker.sv
sim/tb_name_set_table_core.sv
